### hw/rtl/tcw_pkg.sv
package tcw_pkg;

   // Screen geometry
   localparam int SCREEN_ROWS = 25;
   localparam int SCREEN_COLS = 70;
   localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W      = $clog2(CELL_COUNT);

   // Field widths
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 32;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int ROW_SUM_W  = ROW_W + 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_COLOR = 1'd1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   // Queue depth between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Decoded work kinds
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_GLYPH,
      KIND_NEWLINE,
      KIND_BACKSPACE,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   // Back end states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_FILL
   } back_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  cell_char;
      logic [COLOR_W-1:0] cell_color;
      logic [ROW_W-1:0]   pos_row;
      logic [COL_W-1:0]   pos_col;
      logic               did_scroll;
   } rsp_type;

   // Logical row to physical row, given the row at the top of the screen
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_SUM_W-1:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= ROW_SUM_W'(SCREEN_ROWS)) begin
         sum = sum - ROW_SUM_W'(SCREEN_ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   // First cell address of a physical row
   function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
      return ADDR_W'(prow) * ADDR_W'(SCREEN_COLS);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
      return row_base(phys_row(row, top)) + ADDR_W'(col);
   endfunction

endpackage

### hw/rtl/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/tcw_front.sv
module tcw_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tcw_pkg::CMD_W-1:0]     command,
   input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
   input  logic [tcw_pkg::ROW_W-1:0]     read_row,
   input  logic [tcw_pkg::COL_W-1:0]     read_col,
   input  logic                          q_full,
   output logic                          q_push,
   output tcw_pkg::cmd_type              q_cmd
);

   logic in_range;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Reads outside the screen behave like a no-op
   assign in_range = (read_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)) &&
                     (read_col < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS));

   // Classify the word
   always_comb begin
      q_cmd.char_code = char_code;
      q_cmd.row       = read_row;
      q_cmd.col       = read_col;
      case (command)
         tcw_pkg::CMD_PUT: begin
            case (char_code)
               tcw_pkg::CH_NEWLINE:   q_cmd.kind = tcw_pkg::KIND_NEWLINE;
               tcw_pkg::CH_BACKSPACE: q_cmd.kind = tcw_pkg::KIND_BACKSPACE;
               default:               q_cmd.kind = tcw_pkg::KIND_GLYPH;
            endcase
         end
         tcw_pkg::CMD_CLEAR: q_cmd.kind = tcw_pkg::KIND_CLEAR;
         tcw_pkg::CMD_READ:  q_cmd.kind = in_range ? tcw_pkg::KIND_READ : tcw_pkg::KIND_NOP;
         default:            q_cmd.kind = tcw_pkg::KIND_NOP;
      endcase
   end

endmodule

### hw/rtl/tcw_queue.sv
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output tcw_pkg::cmd_type head_cmd
);

   tcw_pkg::cmd_type                slots_ff [tcw_pkg::Q_DEPTH];
   logic [tcw_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   assign full       = count_ff == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slots_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/tcw_back.sv
module tcw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
   input  logic [tcw_pkg::COLOR_W-1:0]   clear_color,
   input  logic                          q_valid,
   input  tcw_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output tcw_pkg::rsp_type              rsp_word
);

   tcw_pkg::back_state_type             state_ff, state_in;
   logic [tcw_pkg::ROW_W-1:0]           cur_row_ff, cur_row_in;
   logic [tcw_pkg::COL_W-1:0]           cur_col_ff, cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]           top_ff, top_in;
   logic [tcw_pkg::ADDR_W-1:0]          fill_addr_ff, fill_addr_in;
   logic [tcw_pkg::COL_W-1:0]           fill_col_ff, fill_col_in;
   logic                                fill_full_ff, fill_full_in;
   logic                                fill_emit_ff, fill_emit_in;
   logic [tcw_pkg::COLOR_W-1:0]         fill_color_ff, fill_color_in;
   logic                                glyph_pend_ff, glyph_pend_in;
   logic [tcw_pkg::CHAR_W-1:0]          pend_char_ff, pend_char_in;
   logic                                pend_scroll_ff, pend_scroll_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic                                slot_free;
   logic                                start;
   logic                                fill_last;
   logic                                row_last;
   logic                                line_full;
   logic [tcw_pkg::ROW_W-1:0]           top_next;
   logic                                rsp_load;
   logic                                ld_cell;
   logic                                ld_scroll;

   logic                                glyph_we, color_we;
   logic [tcw_pkg::ADDR_W-1:0]          wr_addr, rd_addr;
   logic [tcw_pkg::CHAR_W-1:0]          glyph_wdata, glyph_rdata;
   logic [tcw_pkg::COLOR_W-1:0]         color_wdata, color_rdata;

   function automatic logic [tcw_pkg::ROW_W-1:0] row_last_top(
      input logic [tcw_pkg::ROW_W-1:0] top);
      return (top == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)) ? '0 : top + 1'b1;
   endfunction

   // Glyph and color stores share addresses
   tcw_ram #(.WIDTH(tcw_pkg::CHAR_W), .DEPTH(tcw_pkg::CELL_COUNT)) u_glyph_ram (
      .clock (clock),
      .we    (glyph_we),
      .waddr (wr_addr),
      .wdata (glyph_wdata),
      .raddr (rd_addr),
      .rdata (glyph_rdata)
   );

   tcw_ram #(.WIDTH(tcw_pkg::COLOR_W), .DEPTH(tcw_pkg::CELL_COUNT)) u_color_ram (
      .clock (clock),
      .we    (color_we),
      .waddr (wr_addr),
      .wdata (color_wdata),
      .raddr (rd_addr),
      .rdata (color_rdata)
   );

   // Take a new word only when the result slot will be free
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign start     = (state_ff == tcw_pkg::BK_IDLE) && q_valid && slot_free;
   assign q_pop     = start;

   assign row_last  = cur_row_ff == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
   assign line_full = cur_col_ff >= tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS);
   assign top_next  = row_last_top(top_ff);
   assign fill_last = fill_full_ff ?
                      (fill_addr_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) :
                      (fill_col_ff == tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1));
   assign rd_addr   = tcw_pkg::cell_addr(q_cmd.row, q_cmd.col, top_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::BK_IDLE: begin
            if (start) begin
               case (q_cmd.kind)
                  tcw_pkg::KIND_CLEAR:   state_in = tcw_pkg::BK_FILL;
                  tcw_pkg::KIND_READ:    state_in = tcw_pkg::BK_READ;
                  tcw_pkg::KIND_NEWLINE: begin
                     if (row_last) state_in = tcw_pkg::BK_FILL;
                  end
                  tcw_pkg::KIND_GLYPH: begin
                     if (line_full && row_last) state_in = tcw_pkg::BK_FILL;
                  end
                  default: state_in = tcw_pkg::BK_IDLE;
               endcase
            end
         end
         tcw_pkg::BK_READ: state_in = tcw_pkg::BK_IDLE;
         tcw_pkg::BK_FILL: begin
            if (fill_last) state_in = tcw_pkg::BK_IDLE;
         end
         default: state_in = tcw_pkg::BK_IDLE;
      endcase
   end

   // Cursor, store writes, fill sweeps and result loading
   always_comb begin
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      top_in         = top_ff;
      fill_addr_in   = fill_addr_ff;
      fill_col_in    = fill_col_ff;
      fill_full_in   = fill_full_ff;
      fill_emit_in   = fill_emit_ff;
      fill_color_in  = fill_color_ff;
      glyph_pend_in  = glyph_pend_ff;
      pend_char_in   = pend_char_ff;
      pend_scroll_in = pend_scroll_ff;
      glyph_we       = 1'b0;
      color_we       = 1'b0;
      wr_addr        = fill_addr_ff;
      glyph_wdata    = tcw_pkg::CH_SPACE;
      color_wdata    = fill_color_ff;
      rsp_load       = 1'b0;
      ld_cell        = 1'b0;
      ld_scroll      = 1'b0;

      case (state_ff)
         tcw_pkg::BK_IDLE: begin
            if (start) begin
               case (q_cmd.kind)
                  tcw_pkg::KIND_GLYPH: begin
                     glyph_wdata = q_cmd.char_code;
                     color_wdata = text_color;
                     if (line_full && row_last) begin
                        // wrap past the bottom: scroll, glyph lands in column 0
                        top_in         = top_next;
                        fill_addr_in   = tcw_pkg::row_base(top_ff);
                        fill_col_in    = '0;
                        fill_full_in   = 1'b0;
                        fill_emit_in   = 1'b1;
                        fill_color_in  = text_color;
                        glyph_pend_in  = 1'b1;
                        pend_char_in   = q_cmd.char_code;
                        pend_scroll_in = 1'b1;
                        cur_col_in     = tcw_pkg::COL_W'(1);
                     end else if (line_full) begin
                        glyph_we   = 1'b1;
                        color_we   = 1'b1;
                        wr_addr    = tcw_pkg::cell_addr(cur_row_ff + 1'b1, '0, top_ff);
                        cur_row_in = cur_row_ff + 1'b1;
                        cur_col_in = tcw_pkg::COL_W'(1);
                        rsp_load   = 1'b1;
                     end else begin
                        glyph_we   = 1'b1;
                        color_we   = 1'b1;
                        wr_addr    = tcw_pkg::cell_addr(cur_row_ff, cur_col_ff, top_ff);
                        cur_col_in = cur_col_ff + 1'b1;
                        rsp_load   = 1'b1;
                     end
                  end
                  tcw_pkg::KIND_NEWLINE: begin
                     cur_col_in = '0;
                     if (row_last) begin
                        top_in         = top_next;
                        fill_addr_in   = tcw_pkg::row_base(top_ff);
                        fill_col_in    = '0;
                        fill_full_in   = 1'b0;
                        fill_emit_in   = 1'b1;
                        fill_color_in  = text_color;
                        glyph_pend_in  = 1'b0;
                        pend_scroll_in = 1'b1;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                        rsp_load   = 1'b1;
                     end
                  end
                  tcw_pkg::KIND_BACKSPACE: begin
                     // blank the glyph only; the color stays
                     if (cur_col_ff != '0) begin
                        glyph_we   = 1'b1;
                        wr_addr    = tcw_pkg::cell_addr(cur_row_ff, cur_col_ff - 1'b1,
                                                        top_ff);
                        cur_col_in = cur_col_ff - 1'b1;
                     end
                     rsp_load = 1'b1;
                  end
                  tcw_pkg::KIND_CLEAR: begin
                     top_in         = '0;
                     cur_row_in     = '0;
                     cur_col_in     = '0;
                     fill_addr_in   = '0;
                     fill_col_in    = '0;
                     fill_full_in   = 1'b1;
                     fill_emit_in   = 1'b1;
                     fill_color_in  = clear_color;
                     glyph_pend_in  = 1'b0;
                     pend_scroll_in = 1'b0;
                  end
                  tcw_pkg::KIND_READ: begin
                     // read address is driven from the queue head
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         tcw_pkg::BK_READ: begin
            rsp_load = 1'b1;
            ld_cell  = 1'b1;
         end
         tcw_pkg::BK_FILL: begin
            glyph_we     = 1'b1;
            color_we     = 1'b1;
            glyph_wdata  = (glyph_pend_ff && fill_col_ff == '0) ? pend_char_ff
                                                                : tcw_pkg::CH_SPACE;
            fill_addr_in = fill_addr_ff + 1'b1;
            fill_col_in  = fill_col_ff + 1'b1;
            if (fill_last) begin
               glyph_pend_in = 1'b0;
               rsp_load      = fill_emit_ff;
               ld_scroll     = pend_scroll_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Result slot
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.cell_char  = ld_cell ? glyph_rdata : '0;
         rsp_data_in.cell_color = ld_cell ? color_rdata : '0;
         rsp_data_in.pos_row    = cur_row_in;
         rsp_data_in.pos_col    = cur_col_in;
         rsp_data_in.did_scroll = ld_scroll;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_data_ff;

   // Control state; reset starts a sweep that blanks the whole screen
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcw_pkg::BK_FILL;
         cur_row_ff     <= '0;
         cur_col_ff     <= '0;
         top_ff         <= '0;
         fill_addr_ff   <= '0;
         fill_col_ff    <= '0;
         fill_full_ff   <= 1'b1;
         fill_emit_ff   <= 1'b0;
         fill_color_ff  <= '0;
         glyph_pend_ff  <= 1'b0;
         pend_scroll_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_row_ff     <= cur_row_in;
         cur_col_ff     <= cur_col_in;
         top_ff         <= top_in;
         fill_addr_ff   <= fill_addr_in;
         fill_col_ff    <= fill_col_in;
         fill_full_ff   <= fill_full_in;
         fill_emit_ff   <= fill_emit_in;
         fill_color_ff  <= fill_color_in;
         glyph_pend_ff  <= glyph_pend_in;
         pend_scroll_ff <= pend_scroll_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

### hw/rtl/text_console_cell_writer.sv
// Channel | Ports                          | Word
// --------+--------------------------------+-------------------------------------------
// request | req_tvalid/tready/tdata/tuser  | command in tuser; char, row, col in tdata
// result  | rsp_tvalid/tready/tdata        | cell char, cell color, cursor, scroll flag
// config  | csr_we/csr_index/csr_wdata     | 0 text color, 1 clear color
//
// A put or no-op word is queued at its accepting edge; the back end takes it from the queue
// head once idle with a free result slot and loads its result as it takes it; a read first
// passes the registered store read. A scroll adds a sweep of SCREEN_COLS cells, a clear one of CELL_COUNT cells.
// After reset a blanking sweep of all CELL_COUNT (1750) cells runs before the first word starts.
// A held result stalls the back end, and the input once the two-word queue is full.
module text_console_cell_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] char_code, [12:8] read_row, [19:13] read_col
   input  logic [tcw_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] command
   input  logic [tcw_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] cell_char, [39:8] cell_color, [44:40] pos_row, [51:45] pos_col,
   // [52] did_scroll
   output logic [tcw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]         csr_wdata
);

   logic [tcw_pkg::COLOR_W-1:0] text_color_ff, text_color_in;
   logic [tcw_pkg::COLOR_W-1:0] clear_color_ff, clear_color_in;

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   tcw_pkg::cmd_type push_cmd;
   tcw_pkg::cmd_type head_cmd;
   tcw_pkg::rsp_type rsp_word;

   // Configuration registers
   always_comb begin
      text_color_in  = text_color_ff;
      clear_color_in = clear_color_ff;
      if (csr_we) begin
         case (csr_index)
            tcw_pkg::CSR_TEXT_COLOR:  text_color_in  = csr_wdata;
            tcw_pkg::CSR_CLEAR_COLOR: clear_color_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff  <= '0;
         clear_color_ff <= '0;
      end else begin
         text_color_ff  <= text_color_in;
         clear_color_ff <= clear_color_in;
      end
   end

   // Front: accept and classify
   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser),
      .char_code  (req_tdata[7:0]),
      .read_row   (req_tdata[12:8]),
      .read_col   (req_tdata[19:13]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   // Back: cursor, screen store and result
   tcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .text_color  (text_color_ff),
      .clear_color (clear_color_ff),
      .q_valid     (q_valid),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = {3'b000, rsp_word.did_scroll, rsp_word.pos_col,
                       rsp_word.pos_row, rsp_word.cell_color, rsp_word.cell_char};

endmodule
